[rtl/tce_pkg.sv]
// Shared types and constants for the text console character engine.
package tce_pkg;

  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int READ_W     = 11;
  localparam int LINEAR_W   = 11;
  localparam int LINE_W     = 5;
  localparam int COLUMN_W   = 7;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLANK_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_BG = 1'b1;

  localparam logic [COLOR_W-1:0] BLANK_FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BLANK_BG_RESET = 4'h0;

  typedef struct packed {
    logic              wr_en;
    logic              wipe;
    logic [CELL_W-1:0] wr_data;
  } put_ctl_t;

endpackage

[rtl/text_console_char_engine.sv]
// Top level of the text console character engine: sequencing, clear sweep, result register.
// Put word: result valid the next cycle; puts are accepted every cycle while results drain.
// Read word: registered RAM read, then result load in ST_READ, where no new word is accepted.
// Newline on the bottom row: result in the next cycle, then a clear sweep of all
// COLUMNS*ROWS cells during which no word is accepted; config writes are taken throughout.
// Reset: cursor homed, blank colors 15/0, then all COLUMNS*ROWS cells are swept to 0x0F20.
module text_console_char_engine #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [tce_pkg::CHAR_W-1:0]     char_code,
  input  logic [tce_pkg::COLOR_W-1:0]    fore_color,
  input  logic [tce_pkg::COLOR_W-1:0]    back_color,
  input  logic [tce_pkg::READ_W-1:0]     read_cell,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tce_pkg::LINEAR_W-1:0]   cursor_linear,
  output logic [tce_pkg::LINE_W-1:0]     cursor_line,
  output logic [tce_pkg::COLUMN_W-1:0]   cursor_column,
  output logic [tce_pkg::CELL_W-1:0]     cell_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int XW    = AW + 12;
  localparam int RXW   = RW + 6;
  localparam int CXW   = CW + 8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state;

  logic [tce_pkg::COLOR_W-1:0] blank_fg;
  logic [tce_pkg::COLOR_W-1:0] blank_bg;
  logic [tce_pkg::CELL_W-1:0]  clear_word;
  logic [AW-1:0]               clr_addr;
  logic                        rd_ok;

  logic                        in_accept;
  logic                        put_step;
  logic                        load_result;
  logic [RW-1:0]               row_next;
  logic [CW-1:0]               col_next;
  logic [AW-1:0]               lin_next;
  logic [AW-1:0]               put_addr;
  tce_pkg::put_ctl_t           ctl;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tce_pkg::CELL_W-1:0]  ram_wdata;
  logic [tce_pkg::CELL_W-1:0]  ram_rdata;
  logic [XW-1:0]               rd_ext;
  logic                        rd_in_range;
  logic [XW-1:0]               lin_ext;
  logic [RXW-1:0]              row_ext;
  logic [CXW-1:0]              col_ext;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_accept   = in_valid && in_ready;
  assign put_step    = in_accept && (cmd == tce_pkg::CMD_PUT);
  assign load_result = put_step || (state == ST_READ);

  assign rd_ext      = XW'(read_cell);
  assign rd_in_range = (rd_ext < XW'(CELLS));
  assign lin_ext     = XW'(lin_next);
  assign row_ext     = RXW'(row_next);
  assign col_ext     = CXW'(col_next);

  assign ram_we    = (state == ST_CLEAR) || (put_step && ctl.wr_en);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : put_addr;
  assign ram_wdata = (state == ST_CLEAR) ? clear_word : ctl.wr_data;

  tce_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .clk        (clk),
    .rst        (rst),
    .step       (put_step),
    .char_code  (char_code),
    .fore_color (fore_color),
    .back_color (back_color),
    .row_next   (row_next),
    .col_next   (col_next),
    .lin_next   (lin_next),
    .wr_addr    (put_addr),
    .ctl        (ctl)
  );

  tce_cell_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_fg <= tce_pkg::BLANK_FG_RESET;
      blank_bg <= tce_pkg::BLANK_BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tce_pkg::REG_BLANK_FG: blank_fg <= cfg_data;
        tce_pkg::REG_BLANK_BG: blank_bg <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clear_word <= {tce_pkg::BLANK_BG_RESET, tce_pkg::BLANK_FG_RESET, tce_pkg::CH_SPACE};
      out_valid  <= 1'b0;
      rd_ok      <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            if (cmd == tce_pkg::CMD_READ) begin
              rd_ok <= rd_in_range;
              state <= ST_READ;
            end else begin
              cursor_linear <= lin_ext[tce_pkg::LINEAR_W-1:0];
              cursor_line   <= row_ext[tce_pkg::LINE_W-1:0];
              cursor_column <= col_ext[tce_pkg::COLUMN_W-1:0];
              cell_word     <= '0;
              if (ctl.wipe) begin
                clr_addr   <= '0;
                clear_word <= {blank_bg, blank_fg, tce_pkg::CH_SPACE};
                state      <= ST_CLEAR;
              end
            end
          end
        end
        ST_READ: begin
          cursor_linear <= lin_ext[tce_pkg::LINEAR_W-1:0];
          cursor_line   <= row_ext[tce_pkg::LINE_W-1:0];
          cursor_column <= col_ext[tce_pkg::COLUMN_W-1:0];
          cell_word     <= rd_ok ? ram_rdata : '0;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (cmd == tce_pkg::CMD_READ)) |=> (!in_ready && !out_valid))
    else $error("read word not held off for RAM latency");

  a_wipe_clears: assert property (@(posedge clk) disable iff (rst)
    (put_step && ctl.wipe) |=> ((state == ST_CLEAR) && (clr_addr == '0)
                                && (cursor_linear == '0) && out_valid))
    else $error("bottom newline did not home cursor and start clear");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(cursor_column) < COLUMNS))
    else $error("cursor column out of range");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !put_step)
    else $error("put write during clear sweep");

endmodule

[rtl/tce_cell_ram.sv]
// Cell store: simple dual-port synchronous RAM with registered read data.
module tce_cell_ram #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tce_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [tce_pkg::CELL_W-1:0] rdata
);

  logic [tce_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tce_cursor.sv]
// Cursor registers and put-character decode: next cursor and cell write.
module tce_cursor #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4,
  localparam int AW = $clog2(COLUMNS * ROWS),
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLUMNS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [tce_pkg::CHAR_W-1:0]  char_code,
  input  logic [tce_pkg::COLOR_W-1:0] fore_color,
  input  logic [tce_pkg::COLOR_W-1:0] back_color,
  output logic [RW-1:0]               row_next,
  output logic [CW-1:0]               col_next,
  output logic [AW-1:0]               lin_next,
  output logic [AW-1:0]               wr_addr,
  output tce_pkg::put_ctl_t           ctl
);

  localparam int PW = $clog2(TAB_STOP);
  localparam int SW = CW + 5;
  localparam int LAST_PHASE = (COLUMNS - 1) % TAB_STOP;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [CW-1:0] wr_col;
  logic [SW-1:0] tab_sum;
  logic          last_row;
  logic          last_col;

  assign last_row = (row == RW'(ROWS - 1));
  assign last_col = (col == CW'(COLUMNS - 1));
  assign tab_sum  = SW'(col) + SW'(TAB_STOP) - SW'(phase);

  always_comb begin
    row_next    = row;
    col_next    = col;
    phase_next  = phase;
    wr_col      = col;
    ctl.wr_en   = 1'b0;
    ctl.wipe    = 1'b0;
    ctl.wr_data = {back_color, fore_color, char_code};
    if (step) begin
      if (char_code == tce_pkg::CH_NEWLINE) begin
        col_next   = '0;
        phase_next = '0;
        if (last_row) begin
          row_next = '0;
          ctl.wipe = 1'b1;
        end else begin
          row_next = row + RW'(1);
        end
      end else if (char_code == tce_pkg::CH_TAB) begin
        if (tab_sum >= SW'(COLUMNS)) begin
          col_next   = CW'(COLUMNS - 1);
          phase_next = PW'(LAST_PHASE);
        end else begin
          col_next   = tab_sum[CW-1:0];
          phase_next = '0;
        end
      end else if (char_code == tce_pkg::CH_BACKSPACE) begin
        if (col != '0) begin
          col_next    = col - CW'(1);
          wr_col      = col - CW'(1);
          phase_next  = (phase == '0) ? PW'(TAB_STOP - 1) : phase - PW'(1);
          ctl.wr_en   = 1'b1;
          ctl.wr_data = {back_color, fore_color, tce_pkg::CH_SPACE};
        end
      end else begin
        ctl.wr_en = 1'b1;
        if (last_col) begin
          col_next   = '0;
          phase_next = '0;
          row_next   = last_row ? '0 : row + RW'(1);
        end else begin
          col_next   = col + CW'(1);
          phase_next = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + PW'(1);
        end
      end
    end
  end

  assign wr_addr  = AW'(row) * AW'(COLUMNS) + AW'(wr_col);
  assign lin_next = AW'(row_next) * AW'(COLUMNS) + AW'(col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      row   <= '0;
      col   <= '0;
      phase <= '0;
    end else begin
      row   <= row_next;
      col   <= col_next;
      phase <= phase_next;
    end
  end

endmodule

[tb/tce_checker.sv]
// Checker for the text console engine: watches the word and register channels, predicts, compares.
`timescale 1ns / 1ps

module tce_checker #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           cmd,
  input  logic [tce_pkg::CHAR_W-1:0]     char_code,
  input  logic [tce_pkg::COLOR_W-1:0]    fore_color,
  input  logic [tce_pkg::COLOR_W-1:0]    back_color,
  input  logic [tce_pkg::READ_W-1:0]     read_cell,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tce_pkg::LINEAR_W-1:0]   cursor_linear,
  input  logic [tce_pkg::LINE_W-1:0]     cursor_line,
  input  logic [tce_pkg::COLUMN_W-1:0]   cursor_column,
  input  logic [tce_pkg::CELL_W-1:0]     cell_word,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pending,
  output int                             clear_count
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [tce_pkg::LINEAR_W-1:0] linear;
    logic [tce_pkg::LINE_W-1:0]   line;
    logic [tce_pkg::COLUMN_W-1:0] column;
    logic [tce_pkg::CELL_W-1:0]   word;
  } cursor_report_t;

  logic [tce_pkg::CELL_W-1:0]  screen [CELLS];
  logic [tce_pkg::COLOR_W-1:0] blank_fg;
  logic [tce_pkg::COLOR_W-1:0] blank_bg;
  int                          cur_row;
  int                          cur_col;
  int                          mismatches;
  int                          clears;
  cursor_report_t              expected_reports [$];

  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = {blank_bg, blank_fg, tce_pkg::CH_SPACE};
    end
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic cursor_report_t step_console(
    input logic                        c,
    input logic [tce_pkg::CHAR_W-1:0]  ch,
    input logic [tce_pkg::COLOR_W-1:0] fg,
    input logic [tce_pkg::COLOR_W-1:0] bg,
    input logic [tce_pkg::READ_W-1:0]  idx
  );
    cursor_report_t r;
    r.word = '0;
    if (c == tce_pkg::CMD_PUT) begin
      case (ch)
        tce_pkg::CH_NEWLINE: begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS) begin
            wipe_screen();
            clears++;
          end
        end
        tce_pkg::CH_TAB: begin
          cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
          if (cur_col >= COLUMNS) cur_col = COLUMNS - 1;
        end
        tce_pkg::CH_BACKSPACE: begin
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row * COLUMNS + cur_col] = {bg, fg, tce_pkg::CH_SPACE};
          end
        end
        default: begin
          screen[cur_row * COLUMNS + cur_col] = {bg, fg, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) cur_row = 0;
          end
        end
      endcase
    end else if (int'(idx) < CELLS) begin
      r.word = screen[idx];
    end
    r.linear = tce_pkg::LINEAR_W'(cur_row * COLUMNS + cur_col);
    r.line   = tce_pkg::LINE_W'(cur_row);
    r.column = tce_pkg::COLUMN_W'(cur_col);
    return r;
  endfunction

  always @(posedge clk) begin
    cursor_report_t want;
    cursor_report_t got;
    if (rst) begin
      blank_fg = tce_pkg::BLANK_FG_RESET;
      blank_bg = tce_pkg::BLANK_BG_RESET;
      wipe_screen();
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {cursor_linear, cursor_line, cursor_column, cell_word};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t tb: unexpected word linear %0d line %0d column %0d cell %h",
                     $time, got.linear, got.line, got.column, got.word);
        end else begin
          want = expected_reports.pop_front();
          if (want.linear !== got.linear || want.line !== got.line ||
              want.column !== got.column || want.word !== got.word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t tb: mismatch expected %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                       $time, want.linear, want.line, want.column, want.word,
                       got.linear, got.line, got.column, got.word);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tce_pkg::REG_BLANK_FG: blank_fg = cfg_data;
          tce_pkg::REG_BLANK_BG: blank_bg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_reports.push_back(step_console(cmd, char_code, fore_color, back_color,
                                                read_cell));
    end
    pending        <= expected_reports.size();
    mismatch_count <= mismatches;
    clear_count    <= clears;
  end

endmodule

[tb/testbench.sv]
// Top of the text console engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE = 2100;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           cmd;
  logic [tce_pkg::CHAR_W-1:0]     char_code;
  logic [tce_pkg::COLOR_W-1:0]    fore_color;
  logic [tce_pkg::COLOR_W-1:0]    back_color;
  logic [tce_pkg::READ_W-1:0]     read_cell;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [tce_pkg::LINEAR_W-1:0]   cursor_linear;
  logic [tce_pkg::LINE_W-1:0]     cursor_line;
  logic [tce_pkg::COLUMN_W-1:0]   cursor_column;
  logic [tce_pkg::CELL_W-1:0]     cell_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tce_pkg::CFG_DATA_W-1:0] cfg_data;

  int   mismatch_count;
  int   pending;
  int   clear_count;
  int   words_sent = 0;
  int   reads_sent = 0;
  int   cfg_writes = 0;
  logic calm = 1'b0;

  always #5 clk = ~clk;

  text_console_char_engine u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .char_code     (char_code),
    .fore_color    (fore_color),
    .back_color    (back_color),
    .read_cell     (read_cell),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_linear (cursor_linear),
    .cursor_line   (cursor_line),
    .cursor_column (cursor_column),
    .cell_word     (cell_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tce_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .char_code      (char_code),
    .fore_color     (fore_color),
    .back_color     (back_color),
    .read_cell      (read_cell),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_linear  (cursor_linear),
    .cursor_line    (cursor_line),
    .cursor_column  (cursor_column),
    .cell_word      (cell_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .clear_count    (clear_count)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  task automatic send_word(input logic c, input logic [tce_pkg::CHAR_W-1:0] ch,
                           input logic [tce_pkg::COLOR_W-1:0] fg,
                           input logic [tce_pkg::COLOR_W-1:0] bg,
                           input logic [tce_pkg::READ_W-1:0] idx);
    calm = (words_sent >= 450 && words_sent < 650);
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    char_code  <= ch;
    fore_color <= fg;
    back_color <= bg;
    read_cell  <= idx;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (c == tce_pkg::CMD_READ) reads_sent++;
  endtask

  task automatic put_char(input logic [tce_pkg::CHAR_W-1:0] ch,
                          input logic [tce_pkg::COLOR_W-1:0] fg,
                          input logic [tce_pkg::COLOR_W-1:0] bg);
    send_word(tce_pkg::CMD_PUT, ch, fg, bg, tce_pkg::READ_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_at(input int idx);
    send_word(tce_pkg::CMD_READ, tce_pkg::CHAR_W'($urandom_range(0, 255)),
              tce_pkg::COLOR_W'($urandom_range(0, 15)),
              tce_pkg::COLOR_W'($urandom_range(0, 15)), tce_pkg::READ_W'(idx));
  endtask

  // drop valid and let any clear sweep finish before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tce_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tce_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic run_directed();
    read_at(0);
    read_at(1999);
    read_at(2000);
    read_at(2047);
    put_char(8'h00, 4'h0, 4'h0);
    put_char(8'hFF, 4'hF, 4'hF);
    put_char(8'h80, 4'h5, 4'hA);
    put_char(8'h41, 4'h3, 4'hC);
    put_char(tce_pkg::CH_BACKSPACE, 4'hF, 4'hF);
    read_at(3);
    put_char(tce_pkg::CH_TAB, 4'h0, 4'h0);
    put_char(tce_pkg::CH_TAB, 4'h0, 4'h0);
    put_char(tce_pkg::CH_NEWLINE, 4'h0, 4'h0);
    put_char(tce_pkg::CH_BACKSPACE, 4'h6, 4'h9);
    read_at(0);
    read_at(1);
    read_at(2);
    put_char(8'h7F, 4'h3, 4'hC);
    read_at(80);
  endtask

  task automatic run_random(input int target);
    int n;
    int kind;
    int len;
    n = 0;
    while (n < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(1, 100);
        repeat (len) put_char(tce_pkg::CHAR_W'($urandom_range(0, 255)),
                              tce_pkg::COLOR_W'($urandom_range(0, 15)),
                              tce_pkg::COLOR_W'($urandom_range(0, 15)));
      end else if (kind < 55) begin
        len = $urandom_range(1, 24);
        repeat (len) put_char(tce_pkg::CH_TAB, tce_pkg::COLOR_W'($urandom_range(0, 15)),
                              tce_pkg::COLOR_W'($urandom_range(0, 15)));
      end else if (kind < 70) begin
        len = $urandom_range(1, 12);
        repeat (len) put_char(tce_pkg::CH_NEWLINE, tce_pkg::COLOR_W'($urandom_range(0, 15)),
                              tce_pkg::COLOR_W'($urandom_range(0, 15)));
      end else if (kind < 80) begin
        len = $urandom_range(1, 8);
        repeat (len) put_char(tce_pkg::CH_BACKSPACE,
                              tce_pkg::COLOR_W'($urandom_range(0, 15)),
                              tce_pkg::COLOR_W'($urandom_range(0, 15)));
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) read_at($urandom_range(0, 2047));
          else read_at($urandom_range(0, 400));
        end
      end
      n += len;
    end
  endtask

  initial begin
    logic [tce_pkg::CFG_DATA_W-1:0] fg_set [4];
    logic [tce_pkg::CFG_DATA_W-1:0] bg_set [4];
    fg_set = '{4'h0, 4'hF, tce_pkg::CFG_DATA_W'($urandom_range(0, 15)), 4'h0};
    bg_set = '{4'h0, 4'hF, tce_pkg::CFG_DATA_W'($urandom_range(0, 15)), 4'hF};
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = tce_pkg::CMD_PUT;
    char_code  = '0;
    fore_color = '0;
    back_color = '0;
    read_cell  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = tce_pkg::REG_BLANK_FG;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 4; p++) begin
      wait_quiet();
      write_reg(tce_pkg::REG_BLANK_FG, fg_set[p]);
      write_reg(tce_pkg::REG_BLANK_BG, bg_set[p]);
      run_random(220);
      // force a trip off the bottom row
      repeat (25) put_char(tce_pkg::CH_NEWLINE, tce_pkg::COLOR_W'($urandom_range(0, 15)),
                           tce_pkg::COLOR_W'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    $display("tb: %0d words sent (%0d reads), %0d register writes, %0d screen clears",
             words_sent, reads_sent, cfg_writes, clear_count);
    if (pending != 0) $display("tb: %0d expected words never arrived", pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatch_count);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
